@@ rtl/bboc_pkg.sv @@
// bboc_pkg: widths, payload structs and constants shared by the box overlap pipeline.
// Depends on nothing. Used by bboc_project, bboc_penetrate, bboc_correct and the top level.
`default_nettype none

package bboc_pkg;

   localparam int COORD_W        = 32;
   localparam int TRIG_W         = 16;
   localparam int HALF_W         = 31;
   localparam int TRIG_FRAC_BITS = 14;

   // half of trig 1.0, for round half up when dropping the trig fraction
   localparam int ROUND_T = 2 ** (TRIG_FRAC_BITS - 1);

   localparam int D_W       = COORD_W + 1;
   localparam int TPROD_W   = 2 * TRIG_W;
   localparam int TSUM_W    = TPROD_W + 1;
   localparam int AB_W      = 2 * TRIG_W - TRIG_FRAC_BITS;
   localparam int DPROD_W   = TRIG_W + D_W;
   localparam int DSUM_W    = DPROD_W + 1;
   localparam int PROJ_W    = DPROD_W;
   localparam int HPROD_W   = HALF_W + AB_W;
   localparam int RS_TERM_W = (AB_W > TRIG_FRAC_BITS + 1) ? AB_W : TRIG_FRAC_BITS + 1;
   localparam int RSUM_W    = HALF_W + RS_TERM_W + 2;
   localparam int PEN_W     = ((RSUM_W > PROJ_W) ? RSUM_W : PROJ_W) + 1;
   localparam int PC_W      = RSUM_W + 1 - TRIG_FRAC_BITS;
   localparam int AXIS_W    = TRIG_W + 1;
   localparam int CRAW_W    = AXIS_W + PC_W + 1;
   localparam int CR_W      = CRAW_W + 1 - TRIG_FRAC_BITS;

   // register stages between a transfer and its result strobe
   localparam int PIPE_DEPTH = 11;

   localparam logic signed [CR_W-1:0] SAT_HI =
      {{(CR_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
   localparam logic signed [CR_W-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [1:0] {
      AXIS_A0,
      AXIS_A1,
      AXIS_B0,
      AXIS_B1
   } axis_sel_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_center_x;
      logic signed [COORD_W-1:0] first_center_y;
      logic signed [TRIG_W-1:0]  first_cos;
      logic signed [TRIG_W-1:0]  first_sin;
      logic [HALF_W-1:0]         first_half_x;
      logic [HALF_W-1:0]         first_half_y;
      logic signed [COORD_W-1:0] second_center_x;
      logic signed [COORD_W-1:0] second_center_y;
      logic signed [TRIG_W-1:0]  second_cos;
      logic signed [TRIG_W-1:0]  second_sin;
      logic [HALF_W-1:0]         second_half_x;
      logic [HALF_W-1:0]         second_half_y;
   } box_pair_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] a_cos;
      logic signed [TRIG_W-1:0] a_sin;
      logic signed [TRIG_W-1:0] b_cos;
      logic signed [TRIG_W-1:0] b_sin;
      logic                     dx_neg;
      logic                     dy_neg;
   } side_type;

   typedef struct packed {
      logic [HALF_W-1:0]           a_hx;
      logic [HALF_W-1:0]           a_hy;
      logic [HALF_W-1:0]           b_hx;
      logic [HALF_W-1:0]           b_hy;
      logic [HPROD_W-1:0]          a_hx_ab00;
      logic [HPROD_W-1:0]          a_hx_ab01;
      logic [HPROD_W-1:0]          a_hy_ab00;
      logic [HPROD_W-1:0]          a_hy_ab01;
      logic [HPROD_W-1:0]          b_hx_ab00;
      logic [HPROD_W-1:0]          b_hx_ab01;
      logic [HPROD_W-1:0]          b_hy_ab00;
      logic [HPROD_W-1:0]          b_hy_ab01;
      logic [3:0][PROJ_W-1:0]      proj;
      side_type                    side;
   } proj_type;

   typedef struct packed {
      logic              overlap;
      axis_sel_type      axis;
      logic [RSUM_W-1:0] best;
      side_type          side;
   } pick_type;

endpackage

`default_nettype wire

@@ rtl/box_box_overlap_correction.sv @@
// box_box_overlap_correction: top level of the 2D oriented box separating-axis test.
// Instantiates bboc_project, bboc_penetrate and bboc_correct; uses bboc_pkg.
//
// Usage:
//   Drive one box pair on the req_* ports and raise start. A transfer happens at
//   each rising edge where start is high and busy is low. busy is only high while
//   reset is held, so outside reset a new pair may be presented every cycle.
//   Each pair gives exactly one result: rsp_strobe is high for one cycle with
//   rsp_overlap and the correction vector. Throughput is one pair per clock;
//   the path from transfer to strobe runs through the 11 register stages
//   (3 projection, 4 penetration/selection, 4 correction).
//   Results leave in transfer order. The receiver cannot hold results off, and
//   nothing in the block waits on it, so no stall path exists.
//   Synchronous reset clears every valid bit; pairs in flight are dropped and no
//   strobe appears until a pair is taken after reset.
//   On a miss rsp_overlap is low and both correction components read zero.
`default_nettype none

module box_box_overlap_correction (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [bboc_pkg::COORD_W-1:0] req_first_center_x,
   input  logic signed [bboc_pkg::COORD_W-1:0] req_first_center_y,
   input  logic signed [bboc_pkg::TRIG_W-1:0]  req_first_cos,
   input  logic signed [bboc_pkg::TRIG_W-1:0]  req_first_sin,
   input  logic [bboc_pkg::HALF_W-1:0]         req_first_half_x,
   input  logic [bboc_pkg::HALF_W-1:0]         req_first_half_y,
   input  logic signed [bboc_pkg::COORD_W-1:0] req_second_center_x,
   input  logic signed [bboc_pkg::COORD_W-1:0] req_second_center_y,
   input  logic signed [bboc_pkg::TRIG_W-1:0]  req_second_cos,
   input  logic signed [bboc_pkg::TRIG_W-1:0]  req_second_sin,
   input  logic [bboc_pkg::HALF_W-1:0]         req_second_half_x,
   input  logic [bboc_pkg::HALF_W-1:0]         req_second_half_y,
   output logic                                rsp_strobe,
   output logic                                rsp_overlap,
   output logic signed [bboc_pkg::COORD_W-1:0] rsp_correction_x,
   output logic signed [bboc_pkg::COORD_W-1:0] rsp_correction_y
);

   logic                   req_take;
   bboc_pkg::box_pair_type req_pair;
   logic                   proj_valid;
   bboc_pkg::proj_type     proj_data;
   logic                   pick_valid;
   bboc_pkg::pick_type     pick_data;

   // hold off transfers only while in reset
   assign busy     = reset;
   assign req_take = start & ~busy;

   always_comb begin
      req_pair.first_center_x  = req_first_center_x;
      req_pair.first_center_y  = req_first_center_y;
      req_pair.first_cos       = req_first_cos;
      req_pair.first_sin       = req_first_sin;
      req_pair.first_half_x    = req_first_half_x;
      req_pair.first_half_y    = req_first_half_y;
      req_pair.second_center_x = req_second_center_x;
      req_pair.second_center_y = req_second_center_y;
      req_pair.second_cos      = req_second_cos;
      req_pair.second_sin      = req_second_sin;
      req_pair.second_half_x   = req_second_half_x;
      req_pair.second_half_y   = req_second_half_y;
   end

   // center difference, axis dot products, projected extents
   bboc_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_pair   (req_pair),
      .out_valid (proj_valid),
      .out_data  (proj_data)
   );

   // penetration per axis, overlap flag, least-penetration axis
   bboc_penetrate u_penetrate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .in_data   (proj_data),
      .out_valid (pick_valid),
      .out_pick  (pick_data)
   );

   // push-out vector, direction fix and saturation into the result registers
   bboc_correct u_correct (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pick_valid),
      .in_pick     (pick_data),
      .out_valid   (rsp_strobe),
      .out_overlap (rsp_overlap),
      .out_corr_x  (rsp_correction_x),
      .out_corr_y  (rsp_correction_y)
   );

   // a miss must never carry a correction
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_overlap) |-> (rsp_correction_x == '0 && rsp_correction_y == '0))
      else $error("correction nonzero on a miss");

   // every transfer gives a strobe once it has passed all pipeline stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(bboc_pkg::PIPE_DEPTH) rsp_strobe)
      else $error("result missing after transfer");

   // no strobe without a matching transfer
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, bboc_pkg::PIPE_DEPTH))
      else $error("result strobe without a transfer");

endmodule

`default_nettype wire

@@ rtl/bboc_project.sv @@
// bboc_project: three stages that form the center difference, the box-to-box axis
// dot products, the half-extent products and |axis . D| for all four axes. Uses bboc_pkg.
`default_nettype none

module bboc_project (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bboc_pkg::box_pair_type in_pair,
   output logic                   out_valid,
   output bboc_pkg::proj_type     out_data
);

   // stage 1: center difference and trig cross products
   logic                                s1_valid_ff;
   bboc_pkg::box_pair_type              pair1_ff;
   logic signed [bboc_pkg::D_W-1:0]     dx_in, dy_in, dx_ff, dy_ff;
   logic signed [bboc_pkg::TPROD_W-1:0] p_cc_in, p_ss_in, p_cs_in, p_sc_in;
   logic signed [bboc_pkg::TPROD_W-1:0] p_cc_ff, p_ss_ff, p_cs_ff, p_sc_ff;

   assign dx_in = {in_pair.second_center_x[bboc_pkg::COORD_W-1], in_pair.second_center_x}
                - {in_pair.first_center_x[bboc_pkg::COORD_W-1], in_pair.first_center_x};
   assign dy_in = {in_pair.second_center_y[bboc_pkg::COORD_W-1], in_pair.second_center_y}
                - {in_pair.first_center_y[bboc_pkg::COORD_W-1], in_pair.first_center_y};

   assign p_cc_in = $signed(in_pair.first_cos) * $signed(in_pair.second_cos);
   assign p_ss_in = $signed(in_pair.first_sin) * $signed(in_pair.second_sin);
   assign p_cs_in = $signed(in_pair.first_cos) * $signed(in_pair.second_sin);
   assign p_sc_in = $signed(in_pair.first_sin) * $signed(in_pair.second_cos);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pair1_ff <= in_pair;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      p_cc_ff  <= p_cc_in;
      p_ss_ff  <= p_ss_in;
      p_cs_ff  <= p_cs_in;
      p_sc_ff  <= p_sc_in;
   end

   // stage 2: rounded |Ai . Bj| and axis-times-difference products
   logic                                s2_valid_ff;
   bboc_pkg::box_pair_type              pair2_ff;
   logic                                dx_neg2_ff, dy_neg2_ff;
   logic signed [bboc_pkg::TSUM_W-1:0]  t_same, t_cross;
   logic [bboc_pkg::TSUM_W-1:0]         m_same, m_cross, r_same, r_cross;
   logic [bboc_pkg::AB_W-1:0]           ab00_in, ab01_in, ab00_ff, ab01_ff;
   logic signed [bboc_pkg::DPROD_W-1:0] dprod_in [8];
   logic signed [bboc_pkg::DPROD_W-1:0] dprod_ff [8];

   assign t_same  = p_cc_ff + p_ss_ff;
   assign t_cross = p_sc_ff - p_cs_ff;
   assign m_same  = t_same[bboc_pkg::TSUM_W-1]
                  ? (~t_same + bboc_pkg::TSUM_W'(1)) : t_same;
   assign m_cross = t_cross[bboc_pkg::TSUM_W-1]
                  ? (~t_cross + bboc_pkg::TSUM_W'(1)) : t_cross;
   assign r_same  = m_same + bboc_pkg::TSUM_W'(bboc_pkg::ROUND_T);
   assign r_cross = m_cross + bboc_pkg::TSUM_W'(bboc_pkg::ROUND_T);
   assign ab00_in = r_same[bboc_pkg::TRIG_FRAC_BITS +: bboc_pkg::AB_W];
   assign ab01_in = r_cross[bboc_pkg::TRIG_FRAC_BITS +: bboc_pkg::AB_W];

   always_comb begin
      dprod_in[0] = $signed(pair1_ff.first_cos) * dx_ff;
      dprod_in[1] = $signed(pair1_ff.first_sin) * dy_ff;
      dprod_in[2] = $signed(pair1_ff.first_cos) * dy_ff;
      dprod_in[3] = $signed(pair1_ff.first_sin) * dx_ff;
      dprod_in[4] = $signed(pair1_ff.second_cos) * dx_ff;
      dprod_in[5] = $signed(pair1_ff.second_sin) * dy_ff;
      dprod_in[6] = $signed(pair1_ff.second_cos) * dy_ff;
      dprod_in[7] = $signed(pair1_ff.second_sin) * dx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pair2_ff   <= pair1_ff;
      dx_neg2_ff <= dx_ff[bboc_pkg::D_W-1];
      dy_neg2_ff <= dy_ff[bboc_pkg::D_W-1];
      ab00_ff    <= ab00_in;
      ab01_ff    <= ab01_in;
      dprod_ff   <= dprod_in;
   end

   // stage 3: half-extent products and |axis . D|
   logic                               s3_valid_ff;
   logic signed [bboc_pkg::DSUM_W-1:0] dsum [4];
   logic [bboc_pkg::DSUM_W-1:0]        dmag [4];
   bboc_pkg::proj_type                 proj_in, proj_ff;

   always_comb begin
      dsum[0] = dprod_ff[0] + dprod_ff[1];
      dsum[1] = dprod_ff[2] - dprod_ff[3];
      dsum[2] = dprod_ff[4] + dprod_ff[5];
      dsum[3] = dprod_ff[6] - dprod_ff[7];
      for (int k = 0; k < 4; k++) begin
         dmag[k] = dsum[k][bboc_pkg::DSUM_W-1]
                 ? (~dsum[k] + bboc_pkg::DSUM_W'(1)) : dsum[k];
      end
   end

   always_comb begin
      proj_in.a_hx      = pair2_ff.first_half_x;
      proj_in.a_hy      = pair2_ff.first_half_y;
      proj_in.b_hx      = pair2_ff.second_half_x;
      proj_in.b_hy      = pair2_ff.second_half_y;
      proj_in.a_hx_ab00 = pair2_ff.first_half_x * ab00_ff;
      proj_in.a_hx_ab01 = pair2_ff.first_half_x * ab01_ff;
      proj_in.a_hy_ab00 = pair2_ff.first_half_y * ab00_ff;
      proj_in.a_hy_ab01 = pair2_ff.first_half_y * ab01_ff;
      proj_in.b_hx_ab00 = pair2_ff.second_half_x * ab00_ff;
      proj_in.b_hx_ab01 = pair2_ff.second_half_x * ab01_ff;
      proj_in.b_hy_ab00 = pair2_ff.second_half_y * ab00_ff;
      proj_in.b_hy_ab01 = pair2_ff.second_half_y * ab01_ff;
      for (int k = 0; k < 4; k++) begin
         proj_in.proj[k] = dmag[k][bboc_pkg::PROJ_W-1:0];
      end
      proj_in.side.a_cos  = pair2_ff.first_cos;
      proj_in.side.a_sin  = pair2_ff.first_sin;
      proj_in.side.b_cos  = pair2_ff.second_cos;
      proj_in.side.b_sin  = pair2_ff.second_sin;
      proj_in.side.dx_neg = dx_neg2_ff;
      proj_in.side.dy_neg = dy_neg2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      proj_ff <= proj_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = proj_ff;

endmodule

`default_nettype wire

@@ rtl/bboc_penetrate.sv @@
// bboc_penetrate: four stages that build the radius sums, the penetrations and the
// overlap flag, then pick the axis of least penetration. Uses bboc_pkg.
`default_nettype none

module bboc_penetrate (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  bboc_pkg::proj_type in_data,
   output logic               out_valid,
   output bboc_pkg::pick_type out_pick
);

   // stage 1: radius sums
   logic                              n1_valid_ff;
   logic [bboc_pkg::RSUM_W-1:0]       rsum_in [4];
   logic [bboc_pkg::RSUM_W-1:0]       rsum_ff [4];
   logic [3:0][bboc_pkg::PROJ_W-1:0]  proj1_ff;
   bboc_pkg::side_type                side1_ff;

   always_comb begin
      rsum_in[0] = bboc_pkg::RSUM_W'({in_data.a_hx, {bboc_pkg::TRIG_FRAC_BITS{1'b0}}})
                 + bboc_pkg::RSUM_W'(in_data.b_hx_ab00)
                 + bboc_pkg::RSUM_W'(in_data.b_hy_ab01);
      rsum_in[1] = bboc_pkg::RSUM_W'({in_data.a_hy, {bboc_pkg::TRIG_FRAC_BITS{1'b0}}})
                 + bboc_pkg::RSUM_W'(in_data.b_hx_ab01)
                 + bboc_pkg::RSUM_W'(in_data.b_hy_ab00);
      rsum_in[2] = bboc_pkg::RSUM_W'({in_data.b_hx, {bboc_pkg::TRIG_FRAC_BITS{1'b0}}})
                 + bboc_pkg::RSUM_W'(in_data.a_hx_ab00)
                 + bboc_pkg::RSUM_W'(in_data.a_hy_ab01);
      rsum_in[3] = bboc_pkg::RSUM_W'({in_data.b_hy, {bboc_pkg::TRIG_FRAC_BITS{1'b0}}})
                 + bboc_pkg::RSUM_W'(in_data.a_hx_ab01)
                 + bboc_pkg::RSUM_W'(in_data.a_hy_ab00);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_valid_ff <= 1'b0;
      end else begin
         n1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsum_ff  <= rsum_in;
      proj1_ff <= in_data.proj;
      side1_ff <= in_data.side;
   end

   // stage 2: penetrations; touching counts as overlap
   logic                        n2_valid_ff;
   logic [bboc_pkg::PEN_W-1:0]  pen_in [4];
   logic [bboc_pkg::RSUM_W-1:0] pen_ff [4];
   logic                        overlap_in, overlap2_ff;
   bboc_pkg::side_type          side2_ff;

   always_comb begin
      overlap_in = 1'b1;
      for (int k = 0; k < 4; k++) begin
         pen_in[k] = bboc_pkg::PEN_W'(rsum_ff[k]) - bboc_pkg::PEN_W'(proj1_ff[k]);
         if (pen_in[k][bboc_pkg::PEN_W-1]) begin
            overlap_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n2_valid_ff <= 1'b0;
      end else begin
         n2_valid_ff <= n1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pen_ff[k] <= pen_in[k][bboc_pkg::RSUM_W-1:0];
      end
      overlap2_ff <= overlap_in;
      side2_ff    <= side1_ff;
   end

   // stage 3: pairwise minimum, earlier axis kept on a tie
   logic                        n3_valid_ff;
   logic [bboc_pkg::RSUM_W-1:0] m01_in, m23_in, m01_ff, m23_ff;
   bboc_pkg::axis_sel_type      i01_in, i23_in, i01_ff, i23_ff;
   logic                        overlap3_ff;
   bboc_pkg::side_type          side3_ff;

   always_comb begin
      if (pen_ff[1] < pen_ff[0]) begin
         m01_in = pen_ff[1];
         i01_in = bboc_pkg::AXIS_A1;
      end else begin
         m01_in = pen_ff[0];
         i01_in = bboc_pkg::AXIS_A0;
      end
      if (pen_ff[3] < pen_ff[2]) begin
         m23_in = pen_ff[3];
         i23_in = bboc_pkg::AXIS_B1;
      end else begin
         m23_in = pen_ff[2];
         i23_in = bboc_pkg::AXIS_B0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n3_valid_ff <= 1'b0;
      end else begin
         n3_valid_ff <= n2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      m01_ff      <= m01_in;
      m23_ff      <= m23_in;
      i01_ff      <= i01_in;
      i23_ff      <= i23_in;
      overlap3_ff <= overlap2_ff;
      side3_ff    <= side2_ff;
   end

   // stage 4: final minimum
   logic               n4_valid_ff;
   bboc_pkg::pick_type pick_in, pick_ff;

   always_comb begin
      pick_in.overlap = overlap3_ff;
      pick_in.side    = side3_ff;
      if (m23_ff < m01_ff) begin
         pick_in.best = m23_ff;
         pick_in.axis = i23_ff;
      end else begin
         pick_in.best = m01_ff;
         pick_in.axis = i01_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n4_valid_ff <= 1'b0;
      end else begin
         n4_valid_ff <= n3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
   end

   assign out_valid = n4_valid_ff;
   assign out_pick  = pick_ff;

endmodule

`default_nettype wire

@@ rtl/bboc_correct.sv @@
// bboc_correct: four stages that scale the chosen axis by the rounded penetration,
// fix the push-out direction and saturate into the result registers. Uses bboc_pkg.
`default_nettype none

module bboc_correct (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  bboc_pkg::pick_type                  in_pick,
   output logic                                out_valid,
   output logic                                out_overlap,
   output logic signed [bboc_pkg::COORD_W-1:0] out_corr_x,
   output logic signed [bboc_pkg::COORD_W-1:0] out_corr_y
);

   // round to nearest, ties away from zero, dropping the trig fraction
   function automatic logic signed [bboc_pkg::CR_W-1:0] round_away(
      input logic signed [bboc_pkg::CRAW_W-1:0] v
   );
      logic [bboc_pkg::CRAW_W-1:0] mag;
      logic [bboc_pkg::CRAW_W-1:0] sum;
      logic [bboc_pkg::CR_W-1:0]   r;
      mag = v[bboc_pkg::CRAW_W-1] ? (~v + bboc_pkg::CRAW_W'(1)) : v;
      sum = mag + bboc_pkg::CRAW_W'(bboc_pkg::ROUND_T);
      r   = {1'b0, sum[bboc_pkg::CRAW_W-1:bboc_pkg::TRIG_FRAC_BITS]};
      round_away = v[bboc_pkg::CRAW_W-1] ? (~r + bboc_pkg::CR_W'(1)) : r;
   endfunction

   // stage 1: rounded penetration and chosen axis
   logic                                 c1_valid_ff;
   logic [bboc_pkg::RSUM_W:0]            pc_sum;
   logic [bboc_pkg::PC_W-1:0]            pc_in, pc_ff;
   logic signed [bboc_pkg::AXIS_W-1:0]   ac_ext, as_ext, bc_ext, bs_ext;
   logic signed [bboc_pkg::AXIS_W-1:0]   ax_in, ay_in, ax_ff, ay_ff;
   logic                                 ov1_ff, dxn1_ff, dyn1_ff;

   assign pc_sum = {1'b0, in_pick.best} + (bboc_pkg::RSUM_W + 1)'(bboc_pkg::ROUND_T);
   assign pc_in  = pc_sum[bboc_pkg::TRIG_FRAC_BITS +: bboc_pkg::PC_W];

   assign ac_ext = {in_pick.side.a_cos[bboc_pkg::TRIG_W-1], in_pick.side.a_cos};
   assign as_ext = {in_pick.side.a_sin[bboc_pkg::TRIG_W-1], in_pick.side.a_sin};
   assign bc_ext = {in_pick.side.b_cos[bboc_pkg::TRIG_W-1], in_pick.side.b_cos};
   assign bs_ext = {in_pick.side.b_sin[bboc_pkg::TRIG_W-1], in_pick.side.b_sin};

   always_comb begin
      case (in_pick.axis)
         bboc_pkg::AXIS_A0: begin
            ax_in = ac_ext;
            ay_in = as_ext;
         end
         bboc_pkg::AXIS_A1: begin
            ax_in = -as_ext;
            ay_in = ac_ext;
         end
         bboc_pkg::AXIS_B0: begin
            ax_in = bc_ext;
            ay_in = bs_ext;
         end
         bboc_pkg::AXIS_B1: begin
            ax_in = -bs_ext;
            ay_in = bc_ext;
         end
         default: begin
            ax_in = '0;
            ay_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff   <= pc_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      ov1_ff  <= in_pick.overlap;
      dxn1_ff <= in_pick.side.dx_neg;
      dyn1_ff <= in_pick.side.dy_neg;
   end

   // stage 2: axis times penetration
   logic                               c2_valid_ff;
   logic signed [bboc_pkg::CRAW_W-1:0] craw_x_in, craw_y_in, craw_x_ff, craw_y_ff;
   logic                               ov2_ff, dxn2_ff, dyn2_ff;

   assign craw_x_in = ax_ff * $signed({1'b0, pc_ff});
   assign craw_y_in = ay_ff * $signed({1'b0, pc_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_valid_ff <= 1'b0;
      end else begin
         c2_valid_ff <= c1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      craw_x_ff <= craw_x_in;
      craw_y_ff <= craw_y_in;
      ov2_ff    <= ov1_ff;
      dxn2_ff   <= dxn1_ff;
      dyn2_ff   <= dyn1_ff;
   end

   // stage 3: round both components
   logic                             c3_valid_ff;
   logic signed [bboc_pkg::CR_W-1:0] cx_in, cy_in, cx_ff, cy_ff;
   logic                             ov3_ff, dxn3_ff, dyn3_ff;

   assign cx_in = round_away(craw_x_ff);
   assign cy_in = round_away(craw_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_valid_ff <= 1'b0;
      end else begin
         c3_valid_ff <= c2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      ov3_ff  <= ov2_ff;
      dxn3_ff <= dxn2_ff;
      dyn3_ff <= dyn2_ff;
   end

   // stage 4: point away from the second box, saturate, zero on a miss
   logic                                c4_valid_ff;
   logic                                flip;
   logic signed [bboc_pkg::CR_W-1:0]    nx, ny;
   logic signed [bboc_pkg::COORD_W-1:0] sx, sy, corr_x_in, corr_y_in;
   logic signed [bboc_pkg::COORD_W-1:0] corr_x_ff, corr_y_ff;
   logic                                overlap_ff;

   always_comb begin
      if (cx_ff > cy_ff) begin
         flip = (dxn3_ff == cx_ff[bboc_pkg::CR_W-1]);
      end else begin
         flip = (dyn3_ff == cy_ff[bboc_pkg::CR_W-1]);
      end
      nx = flip ? -cx_ff : cx_ff;
      ny = flip ? -cy_ff : cy_ff;

      if (nx > bboc_pkg::SAT_HI) begin
         sx = bboc_pkg::SAT_HI[bboc_pkg::COORD_W-1:0];
      end else if (nx < bboc_pkg::SAT_LO) begin
         sx = bboc_pkg::SAT_LO[bboc_pkg::COORD_W-1:0];
      end else begin
         sx = nx[bboc_pkg::COORD_W-1:0];
      end
      if (ny > bboc_pkg::SAT_HI) begin
         sy = bboc_pkg::SAT_HI[bboc_pkg::COORD_W-1:0];
      end else if (ny < bboc_pkg::SAT_LO) begin
         sy = bboc_pkg::SAT_LO[bboc_pkg::COORD_W-1:0];
      end else begin
         sy = ny[bboc_pkg::COORD_W-1:0];
      end

      corr_x_in = ov3_ff ? sx : '0;
      corr_y_in = ov3_ff ? sy : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_valid_ff <= 1'b0;
      end else begin
         c4_valid_ff <= c3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      overlap_ff <= ov3_ff;
      corr_x_ff  <= corr_x_in;
      corr_y_ff  <= corr_y_in;
   end

   assign out_valid   = c4_valid_ff;
   assign out_overlap = overlap_ff;
   assign out_corr_x  = corr_x_ff;
   assign out_corr_y  = corr_y_ff;

endmodule

`default_nettype wire

@@ tb/sv/bboc_contact_pkg.sv @@
// bboc_contact_pkg: predictor of the box pair overlap result and the scoreboard class
// that holds expected results. Depends on bboc_pkg for payload types and widths.
package bboc_contact_pkg;

   import bboc_pkg::*;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] push_x;
      logic signed [COORD_W-1:0] push_y;
   } contact_type;

   // round to nearest, ties away from zero
   function automatic longint round_shift(input longint value, input int bits);
      longint mag;
      mag = (value < 0) ? -value : value;
      mag = (mag + (longint'(1) << (bits - 1))) >>> bits;
      return (value < 0) ? -mag : mag;
   endfunction

   function automatic longint abs64(input longint value);
      return (value < 0) ? -value : value;
   endfunction

   function automatic longint clamp_coord(input longint value);
      longint hi;
      longint lo;
      hi = (longint'(1) << (COORD_W - 1)) - 1;
      lo = -(longint'(1) << (COORD_W - 1));
      if (value > hi) return hi;
      if (value < lo) return lo;
      return value;
   endfunction

   function automatic contact_type predict_contact(input box_pair_type pair);
      contact_type res;
      longint      one_t;
      longint      a_x, a_y, a_c, a_s, a_hx, a_hy;
      longint      b_x, b_y, b_c, b_s, b_hx, b_hy;
      longint      dx, dy;
      longint      dot00, dot01, dot10, dot11;
      longint      ux[4];
      longint      uy[4];
      longint      reach[4];
      longint      depth, least, push_x, push_y;
      int          pick;
      bit          flip;
      one_t = longint'(1) << TRIG_FRAC_BITS;
      a_x   = longint'($signed(pair.first_center_x));
      a_y   = longint'($signed(pair.first_center_y));
      a_c   = longint'($signed(pair.first_cos));
      a_s   = longint'($signed(pair.first_sin));
      a_hx  = longint'(pair.first_half_x);
      a_hy  = longint'(pair.first_half_y);
      b_x   = longint'($signed(pair.second_center_x));
      b_y   = longint'($signed(pair.second_center_y));
      b_c   = longint'($signed(pair.second_cos));
      b_s   = longint'($signed(pair.second_sin));
      b_hx  = longint'(pair.second_half_x);
      b_hy  = longint'(pair.second_half_y);
      dx    = b_x - a_x;
      dy    = b_y - a_y;

      ux[0] = a_c;  uy[0] = a_s;
      ux[1] = -a_s; uy[1] = a_c;
      ux[2] = b_c;  uy[2] = b_s;
      ux[3] = -b_s; uy[3] = b_c;

      dot00 = round_shift(abs64(a_c * b_c + a_s * b_s), TRIG_FRAC_BITS);
      dot01 = round_shift(abs64(-a_c * b_s + a_s * b_c), TRIG_FRAC_BITS);
      dot10 = round_shift(abs64(-a_s * b_c + a_c * b_s), TRIG_FRAC_BITS);
      dot11 = round_shift(abs64(a_s * b_s + a_c * b_c), TRIG_FRAC_BITS);

      reach[0] = a_hx * one_t + b_hx * dot00 + b_hy * dot01;
      reach[1] = a_hy * one_t + b_hx * dot10 + b_hy * dot11;
      reach[2] = b_hx * one_t + a_hx * dot00 + a_hy * dot10;
      reach[3] = b_hy * one_t + a_hx * dot01 + a_hy * dot11;

      res   = '0;
      least = 0;
      pick  = 0;
      for (int k = 0; k < 4; k++) begin
         depth = reach[k] - abs64(ux[k] * dx + uy[k] * dy);
         if (depth < 0) return res;
         if (k == 0 || depth < least) begin
            least = depth;
            pick  = k;
         end
      end

      depth  = round_shift(least, TRIG_FRAC_BITS);
      push_x = round_shift(ux[pick] * depth, TRIG_FRAC_BITS);
      push_y = round_shift(uy[pick] * depth, TRIG_FRAC_BITS);
      if (push_x > push_y) flip = ((dx < 0) == (push_x < 0));
      else                 flip = ((dy < 0) == (push_y < 0));
      if (flip) begin
         push_x = -push_x;
         push_y = -push_y;
      end
      res.hit    = 1'b1;
      res.push_x = COORD_W'(clamp_coord(push_x));
      res.push_y = COORD_W'(clamp_coord(push_y));
      return res;
   endfunction

   class contact_scoreboard;
      contact_type pending_contacts[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_pair(input box_pair_type pair);
         pending_contacts.push_back(predict_contact(pair));
      endfunction

      function void check_result(input logic hit, input logic signed [COORD_W-1:0] push_x,
                                 input logic signed [COORD_W-1:0] push_y);
         contact_type want;
         if (pending_contacts.size() == 0) begin
            $error("rsp_strobe: result with no transfer outstanding");
            mismatches++;
            return;
         end
         want = pending_contacts.pop_front();
         if (hit !== want.hit) begin
            $error("rsp_overlap: expected %0d, got %0d", want.hit, hit);
            mismatches++;
         end
         if (push_x !== want.push_x) begin
            $error("rsp_correction_x: expected %0d, got %0d", want.push_x, push_x);
            mismatches++;
         end
         if (push_y !== want.push_y) begin
            $error("rsp_correction_y: expected %0d, got %0d", want.push_y, push_y);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_contacts.size();
      endfunction
   endclass

endpackage

@@ tb/sv/box_box_overlap_correction_test.sv @@
// box_box_overlap_correction_test: self-checking bench for the oriented box overlap block.
// Depends on bboc_pkg and bboc_contact_pkg; drives directed pairs, then random bursts.
module box_box_overlap_correction_test;

   timeunit 1ns;
   timeprecision 1ps;

   import bboc_pkg::*;
   import bboc_contact_pkg::*;

   localparam int          RANDOM_PAIRS = 900;
   localparam longint      ONE_C        = 65536;    // 1.0 in coordinate format
   localparam int          ONE_T        = 16384;    // 1.0 in trig format
   localparam int          DIAG_T       = 11585;    // cos 45 degrees
   localparam int          INT_MAX      = 32'sh7FFF_FFFF;
   localparam int          INT_MIN      = 32'sh8000_0000;
   localparam int unsigned HALF_MAX     = 32'h7FFF_FFFF;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic rsp_strobe;
   logic rsp_overlap;
   logic signed [COORD_W-1:0] rsp_correction_x;
   logic signed [COORD_W-1:0] rsp_correction_y;
   box_pair_type req;

   contact_scoreboard board = new();

   box_box_overlap_correction u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_first_center_x  (req.first_center_x),
      .req_first_center_y  (req.first_center_y),
      .req_first_cos       (req.first_cos),
      .req_first_sin       (req.first_sin),
      .req_first_half_x    (req.first_half_x),
      .req_first_half_y    (req.first_half_y),
      .req_second_center_x (req.second_center_x),
      .req_second_center_y (req.second_center_y),
      .req_second_cos      (req.second_cos),
      .req_second_sin      (req.second_sin),
      .req_second_half_x   (req.second_half_x),
      .req_second_half_y   (req.second_half_y),
      .rsp_strobe          (rsp_strobe),
      .rsp_overlap         (rsp_overlap),
      .rsp_correction_x    (rsp_correction_x),
      .rsp_correction_y    (rsp_correction_y)
   );

   always #4 clock = ~clock;

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Check every strobed result against the oldest prediction. Outputs are read in
   // the active region of the edge, so they hold what the block drove in the cycle
   // that this edge ends.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         board.check_result(rsp_overlap, rsp_correction_x, rsp_correction_y);
   end

   function automatic box_pair_type make_pair(
      input longint a_x, input longint a_y, input int a_c, input int a_s,
      input longint a_hx, input longint a_hy,
      input longint b_x, input longint b_y, input int b_c, input int b_s,
      input longint b_hx, input longint b_hy);
      box_pair_type pair;
      pair.first_center_x  = COORD_W'(a_x);
      pair.first_center_y  = COORD_W'(a_y);
      pair.first_cos       = TRIG_W'(a_c);
      pair.first_sin       = TRIG_W'(a_s);
      pair.first_half_x    = HALF_W'(a_hx);
      pair.first_half_y    = HALF_W'(a_hy);
      pair.second_center_x = COORD_W'(b_x);
      pair.second_center_y = COORD_W'(b_y);
      pair.second_cos      = TRIG_W'(b_c);
      pair.second_sin      = TRIG_W'(b_s);
      pair.second_half_x   = HALF_W'(b_hx);
      pair.second_half_y   = HALF_W'(b_hy);
      return pair;
   endfunction

   // Random magnitude below 2^bits, bits capped at 31.
   function automatic longint rand_mag(input int bits);
      return longint'($urandom & ((32'd1 << bits) - 32'd1));
   endfunction

   function automatic longint rand_signed(input int bits);
      return $urandom_range(1) ? -rand_mag(bits) : rand_mag(bits);
   endfunction

   // Pick an orientation: mostly near unit length, some axis aligned, some arbitrary.
   function automatic void pick_axis(output int c, output int s);
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) begin
         c = int'($urandom_range(32768)) - ONE_T;
         s = int'($urandom_range(32768)) - ONE_T;
      end else if (roll == 1) begin
         case ($urandom_range(3))
            0: begin c = ONE_T;  s = 0;      end
            1: begin c = 0;      s = ONE_T;  end
            2: begin c = -ONE_T; s = 0;      end
            default: begin c = 0; s = -ONE_T; end
         endcase
      end else begin
         c = int'($urandom_range(32768)) - ONE_T;
         s = $rtoi($sqrt(268435456.0 - real'(c * c)) + 0.5);
         if ($urandom_range(1)) s = -s;
      end
   endfunction

   // Most pairs sit close at a shared random scale so that overlaps and
   // near misses dominate; the rest are raw noise, huge boxes, or exact contact.
   function automatic box_pair_type random_pair();
      box_pair_type pair;
      int           mode, scale, a_c, a_s, b_c, b_s;
      longint       a_x, a_y, a_hx, a_hy, b_hx, b_hy;
      logic [319:0] noise;
      mode  = $urandom_range(99);
      scale = $urandom_range(28, 4);
      a_x   = longint'($signed($urandom));
      a_y   = longint'($signed($urandom));
      pick_axis(a_c, a_s);
      pick_axis(b_c, b_s);
      if (mode < 70) begin
         a_hx = rand_mag(scale);
         a_hy = rand_mag(scale);
         b_hx = rand_mag(scale);
         b_hy = rand_mag(scale);
         pair = make_pair(a_x, a_y, a_c, a_s, a_hx, a_hy,
                          a_x + rand_signed(scale + 1), a_y + rand_signed(scale + 1),
                          b_c, b_s, b_hx, b_hy);
      end else if (mode < 85) begin
         noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom};
         pair = box_pair_type'(noise[$bits(box_pair_type)-1:0]);
         pair.first_cos  = TRIG_W'(a_c);
         pair.first_sin  = TRIG_W'(a_s);
         pair.second_cos = TRIG_W'(b_c);
         pair.second_sin = TRIG_W'(b_s);
      end else if (mode < 95) begin
         pair = make_pair(a_x, a_y, a_c, a_s,
                          HALF_MAX - rand_mag(29), HALF_MAX - rand_mag(29),
                          a_x + rand_signed(31), a_y + rand_signed(31), b_c, b_s,
                          HALF_MAX - rand_mag(29), HALF_MAX - rand_mag(29));
      end else begin
         // exact contact of two axis-aligned boxes along x
         a_hx = rand_mag(scale);
         b_hx = rand_mag(scale);
         pair = make_pair(a_x, a_y, ONE_T, 0, a_hx, rand_mag(scale),
                          a_x + a_hx + b_hx, a_y, ONE_T, 0, b_hx, rand_mag(scale));
      end
      return pair;
   endfunction

   // Present a pair and hold it until the transfer edge, then record it.
   task automatic send_pair(input box_pair_type pair);
      req   <= pair;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_pair(pair);
   endtask

   // Drop start for a gap of the given number of cycles.
   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      box_pair_type directed[$];
      int           sent;
      int           burst;
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: degenerate boxes, touching, ties, sign rule, orientation
      // extremes and saturation.
      directed.push_back(make_pair(0, 0, ONE_T, 0, 0, 0, 0, 0, ONE_T, 0, 0, 0));
      directed.push_back(make_pair(0, 0, ONE_T, 0, 2*ONE_C, ONE_C,
                                   3*ONE_C, ONE_C/2, ONE_T, 0, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, ONE_T, 0, 2*ONE_C, ONE_C,
                                   5*ONE_C, 0, ONE_T, 0, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, ONE_T, 0, 2*ONE_C, ONE_C,
                                   4*ONE_C, 0, ONE_T, 0, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(ONE_C, ONE_C, ONE_T, 0, ONE_C, ONE_C,
                                   ONE_C, ONE_C, ONE_T, 0, ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, ONE_T, 0, 2*ONE_C, 2*ONE_C,
                                   -3*ONE_C, -ONE_C/2, ONE_T, 0, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, ONE_T, 0, 2*ONE_C, ONE_C,
                                   0, 3*ONE_C/2, ONE_T, 0, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, ONE_T, 0, 2*ONE_C, ONE_C,
                                   0, -3*ONE_C/2, ONE_T, 0, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, DIAG_T, DIAG_T, 3*ONE_C, ONE_C/4,
                                   2*ONE_C, -2*ONE_C, ONE_T, 0, ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, ONE_T, 0, 3*ONE_C, ONE_C,
                                   ONE_C, 2*ONE_C, 0, ONE_T, 3*ONE_C, ONE_C/2));
      directed.push_back(make_pair(0, 0, 0, 0, ONE_C, ONE_C,
                                   ONE_C, ONE_C, 0, 0, ONE_C, ONE_C));
      directed.push_back(make_pair(0, 0, ONE_T, ONE_T, ONE_C, ONE_C,
                                   ONE_C/2, -ONE_C/3, ONE_T, ONE_T, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(ONE_C, 0, -ONE_T, ONE_T, ONE_C, 2*ONE_C,
                                   0, ONE_C, ONE_T, -ONE_T, 2*ONE_C, ONE_C));
      directed.push_back(make_pair(INT_MIN, INT_MIN, -ONE_T, ONE_T, HALF_MAX, HALF_MAX,
                                   INT_MAX, INT_MAX, ONE_T, -ONE_T, HALF_MAX, HALF_MAX));
      directed.push_back(make_pair(INT_MAX, INT_MAX, ONE_T, 0, HALF_MAX, HALF_MAX,
                                   INT_MIN, INT_MIN, ONE_T, 0, HALF_MAX, HALF_MAX));
      directed.push_back(make_pair(0, 0, DIAG_T, -DIAG_T, HALF_MAX, HALF_MAX,
                                   0, 0, -DIAG_T, DIAG_T, HALF_MAX, HALF_MAX));
      directed.push_back(make_pair(0, 0, -ONE_T, 0, HALF_MAX, 1,
                                   1, 0, 0, -ONE_T, HALF_MAX, 1));
      directed.push_back(make_pair(INT_MIN, 0, ONE_T, 0, 0, 0,
                                   INT_MAX, 0, ONE_T, 0, 0, 0));
      foreach (directed[i]) send_pair(directed[i]);
      pause(3);

      // Random part: bursts of transfers with random gaps, some long stretches
      // back to back.
      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         burst = ($urandom_range(3) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 1);
         for (int i = 0; i < burst && sent < RANDOM_PAIRS; i++) begin
            send_pair(random_pair());
            sent++;
         end
         if ($urandom_range(3) != 0) pause($urandom_range(12, 1));
      end
      start <= 1'b0;

      // Drain: wait for every outstanding result, then wait past the pipeline depth
      // to catch any stray strobe.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
